### design/ad_env_pkg.sv
// Shared constants and the time-to-step mapping for the attack-decay envelope.
// No dependencies; used by the top level, by its port checker and by the testbench.
package ad_env_pkg;

  localparam int unsigned TimeWidth  = 16;
  localparam int unsigned LevelWidth = 16;
  localparam int unsigned PhaseWidth = 32;
  localparam int unsigned StepWidth  = 25;
  localparam int unsigned TimeShift  = 8;

  localparam logic [StepWidth-1:0]  SlowStep   = StepWidth'(100);
  localparam logic [StepWidth-1:0]  StepOffset = StepWidth'(1000);
  localparam logic [LevelWidth-1:0] LevelMax   = {LevelWidth{1'b1}};
  localparam logic [LevelWidth-1:0] LevelZero  = '0;

  // Largest level seen on the first tick after a trigger: max step >> 16.
  localparam logic [LevelWidth-1:0] FirstTickMax = LevelWidth'(256);

  typedef logic [StepWidth-1:0] step_t;

  // A time of zero gives the slow step, anything else (t << 8) + 1000.
  function automatic step_t time_to_step(input logic [TimeWidth-1:0] t);
    step_t shifted;
    shifted = {1'b0, t, {TimeShift{1'b0}}};
    if (t == '0) begin
      return SlowStep;
    end
    return shifted + StepOffset;
  endfunction

endpackage

### design/attack_decay_envelope.sv
// Linear attack-decay envelope: one request per cycle, result in an output register.
// A trigger (command 1) restarts the attack and gives no result; a tick (command 0)
// advances the 32-bit phase by the segment's step while not dead and returns one 16-bit level.
// The state update and the level are one 32-bit add and a carry test, written at the
// accepting edge, and the level appears on the output the cycle after. The block
// takes a new request every cycle as long as the output register is empty or
// being drained in that cycle. Depends on ad_env_pkg.
module attack_decay_envelope import ad_env_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  command_i,
  input  logic [TimeWidth-1:0]  attack_time_i,
  input  logic [TimeWidth-1:0]  decay_time_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [LevelWidth-1:0] level_o
);

  typedef enum logic [1:0] {
    SegDead   = 2'd0,
    SegAttack = 2'd1,
    SegDecay  = 2'd2
  } segment_e;

  segment_e               segment_q, segment_d;
  logic [PhaseWidth-1:0]  phase_q, phase_d;
  step_t                  step_q, step_d;
  logic [TimeWidth-1:0]   decay_q, decay_d;
  logic                   out_valid_q, out_valid_d;
  logic [LevelWidth-1:0]  level_q, level_d;

  logic                   accept;
  logic [PhaseWidth:0]    sum;
  logic [LevelWidth-1:0]  tick_level;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign sum        = {1'b0, phase_q} + {{(PhaseWidth + 1 - StepWidth){1'b0}}, step_q};

  always_comb begin
    segment_d  = segment_q;
    phase_d    = phase_q;
    step_d     = step_q;
    decay_d    = decay_q;
    tick_level = LevelZero;
    case (segment_q)
      SegAttack: begin
        if (sum[PhaseWidth]) begin
          segment_d  = SegDecay;
          phase_d    = '0;
          step_d     = time_to_step(decay_q);
          tick_level = LevelMax;
        end else begin
          phase_d    = sum[PhaseWidth-1:0];
          tick_level = sum[PhaseWidth-1 -: LevelWidth];
        end
      end
      SegDecay: begin
        phase_d = sum[PhaseWidth-1:0];
        if (sum[PhaseWidth]) begin
          segment_d = SegDead;
        end else begin
          tick_level = ~sum[PhaseWidth-1 -: LevelWidth];
        end
      end
      default: begin
        // dead, or the unused code: hold state, report zero
      end
    endcase
    if (command_i) begin
      segment_d = SegAttack;
      phase_d   = '0;
      step_d    = time_to_step(attack_time_i);
      decay_d   = decay_time_i;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    level_d     = level_q;
    if (accept && !command_i) begin
      out_valid_d = 1'b1;
      level_d     = tick_level;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      segment_q   <= SegDead;
      phase_q     <= '0;
      step_q      <= '0;
      decay_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        segment_q <= segment_d;
        phase_q   <= phase_d;
        step_q    <= step_d;
        decay_q   <= decay_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    level_q <= level_d;
  end

  assign out_valid_o = out_valid_q;
  assign level_o     = level_q;

endmodule

### design/ad_env_checker.sv
// Port-level checks for attack_decay_envelope, attached by the bind below.
// Depends on ad_env_pkg.
module ad_env_checker import ad_env_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  command_i,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [LevelWidth-1:0] level_o
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(level_o))
    else $error("result changed while stalled");

  // every tick request shows a result next cycle
  a_tick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !command_i |=> out_valid_o)
    else $error("tick request gave no result");

  // a trigger gives no result
  a_trig_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && command_i && (!out_valid_o || out_ready_i) |=> !out_valid_o)
    else $error("trigger request gave a result");

  // the first tick right after a trigger is one step from zero
  a_first_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !command_i && $past(in_acc && command_i) |=> level_o <= FirstTickMax)
    else $error("first tick after trigger too large");

endmodule

bind attack_decay_envelope ad_env_checker u_ad_env_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .command_i   (command_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .level_o     (level_o)
);

### sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for attack_decay_envelope: clocked driver and monitor around the DUT.
// Levels are predicted per accepted request and checked in order. Depends on ad_env_pkg.
module testbench;
  import ad_env_pkg::*;

  localparam logic CmdTick    = 1'b0;
  localparam logic CmdTrigger = 1'b1;

  localparam int ModeLength    = 400;
  localparam int HoldCycles    = 300;
  localparam int WatchdogLimit = 2000;
  localparam int PrintLimit    = 40;

  typedef enum logic [1:0] {
    SegDead   = 2'd0,
    SegAttack = 2'd1,
    SegDecay  = 2'd2
  } env_seg_e;

  typedef enum logic [1:0] {
    IdleNone     = 2'd0,
    IdleSender   = 2'd1,
    IdleReceiver = 2'd2,
    IdleBoth     = 2'd3
  } idle_mode_e;

  typedef struct packed {
    logic                 command;
    logic [TimeWidth-1:0] attack_time;
    logic [TimeWidth-1:0] decay_time;
  } env_req_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  in_valid_i    = 1'b0;
  logic                  in_ready_o;
  logic                  command_i     = CmdTick;
  logic [TimeWidth-1:0]  attack_time_i = '0;
  logic [TimeWidth-1:0]  decay_time_i  = '0;
  logic                  out_valid_o;
  logic                  out_ready_i   = 1'b0;
  logic [LevelWidth-1:0] level_o;

  attack_decay_envelope dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .attack_time_i (attack_time_i),
    .decay_time_i  (decay_time_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .level_o       (level_o)
  );

  always #5 clk_i = ~clk_i;

  env_req_t              pending_reqs[$];
  logic [LevelWidth-1:0] expected_levels[$];

  // Predicted envelope state
  env_seg_e              env_seg      = SegDead;
  logic [PhaseWidth-1:0] env_phase    = '0;
  logic [StepWidth-1:0]  env_step     = '0;
  logic [TimeWidth-1:0]  stored_decay = '0;

  int error_count    = 0;
  int req_count      = 0;
  int trigger_count  = 0;
  int levels_checked = 0;
  int attack_wraps   = 0;
  int decay_wraps    = 0;

  idle_mode_e idle_mode      = IdleNone;
  int         mode_cycles    = 0;
  int         sender_idle_pct = 0;
  int         recv_stall_pct  = 0;
  int         hold_token     = 0;
  int         hold_seen      = 0;
  int         hold_left      = 0;
  int         stall_cycles   = 0;

  function automatic logic [StepWidth-1:0] rate_to_step(input logic [TimeWidth-1:0] t);
    if (t == '0) begin
      return SlowStep;
    end
    return (StepWidth'(t) << TimeShift) + StepOffset;
  endfunction

  // Applies one accepted request to the predicted state; ticks queue a level.
  task automatic advance_envelope(input logic cmd, input logic [TimeWidth-1:0] at,
                                  input logic [TimeWidth-1:0] dt);
    logic [PhaseWidth:0]   sum;
    logic [LevelWidth-1:0] lvl;
    if (cmd == CmdTrigger) begin
      stored_decay = dt;
      env_seg      = SegAttack;
      env_phase    = '0;
      env_step     = rate_to_step(at);
      trigger_count++;
    end else begin
      if (env_seg == SegAttack || env_seg == SegDecay) begin
        sum       = {1'b0, env_phase} + (PhaseWidth+1)'(env_step);
        env_phase = sum[PhaseWidth-1:0];
        if (sum[PhaseWidth]) begin
          if (env_seg == SegAttack) begin
            env_seg   = SegDecay;
            env_phase = '0;
            env_step  = rate_to_step(stored_decay);
            attack_wraps++;
          end else begin
            env_seg = SegDead;
            decay_wraps++;
          end
        end
      end
      case (env_seg)
        SegAttack: lvl = env_phase[PhaseWidth-1 -: LevelWidth];
        SegDecay:  lvl = LevelMax - env_phase[PhaseWidth-1 -: LevelWidth];
        default:   lvl = LevelZero;
      endcase
      expected_levels.push_back(lvl);
    end
  endtask

  task automatic report_mismatch(input string msg);
    if (error_count < PrintLimit) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    error_count++;
  endtask

  // Idle mode rotates on its own cycle counter so gaps land on every envelope segment.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_cycles     <= 0;
      idle_mode       <= IdleNone;
      sender_idle_pct <= 0;
      recv_stall_pct  <= 0;
    end else if (mode_cycles == ModeLength - 1) begin
      mode_cycles <= 0;
      idle_mode   <= idle_mode_e'(idle_mode + 2'd1);
      case (idle_mode_e'(idle_mode + 2'd1))
        IdleSender: begin
          sender_idle_pct <= 70;
          recv_stall_pct  <= 0;
        end
        IdleReceiver: begin
          sender_idle_pct <= 0;
          recv_stall_pct  <= 70;
        end
        IdleBoth: begin
          sender_idle_pct <= 13;
          recv_stall_pct  <= 13;
        end
        default: begin
          sender_idle_pct <= 0;
          recv_stall_pct  <= 0;
        end
      endcase
    end else begin
      mode_cycles <= mode_cycles + 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    env_req_t next_req;
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      command_i     <= CmdTick;
      attack_time_i <= '0;
      decay_time_i  <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        advance_envelope(command_i, attack_time_i, decay_time_i);
        req_count++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          next_req       = pending_reqs.pop_front();
          in_valid_i    <= 1'b1;
          command_i     <= next_req.command;
          attack_time_i <= next_req.attack_time;
          decay_time_i  <= next_req.decay_time;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : check_levels
    logic [LevelWidth-1:0] want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_levels.size() == 0) begin
          report_mismatch($sformatf("level %0d with no request pending", level_o));
        end else begin
          want = expected_levels.pop_front();
          if (level_o !== want) begin
            report_mismatch($sformatf("level got %0d want %0d", level_o, want));
          end
          levels_checked++;
        end
      end
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles <= 0;
      end else if (stall_cycles == WatchdogLimit) begin
        $display("timeout: no request or level moved for %0d cycles", WatchdogLimit);
        $display("FAILURE");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic push_req(input logic cmd, input logic [TimeWidth-1:0] at,
                          input logic [TimeWidth-1:0] dt);
    env_req_t r;
    r.command     = cmd;
    r.attack_time = at;
    r.decay_time  = dt;
    pending_reqs.push_back(r);
  endtask

  // Mostly fast times so envelopes wrap through both segments within a run.
  function automatic logic [TimeWidth-1:0] pick_time();
    if ($urandom_range(99) < 75) begin
      return TimeWidth'($urandom_range(16'hE000, 16'hFFFF));
    end
    return TimeWidth'($urandom);
  endfunction

  task automatic push_ticks(input int n);
    for (int i = 0; i < n; i++) begin
      push_req(CmdTick, TimeWidth'($urandom), TimeWidth'($urandom));
    end
  endtask

  // Well-formed envelopes (trigger then a run of ticks) with some random noise.
  task automatic push_random(input int target);
    int made;
    int n;
    made = 0;
    while (made < target) begin
      if ($urandom_range(99) < 80 && target - made >= 2) begin
        push_req(CmdTrigger, pick_time(), pick_time());
        n = $urandom_range(1, 650);
        if (n > target - made - 1) begin
          n = target - made - 1;
        end
        push_ticks(n);
        made += n + 1;
      end else begin
        n = $urandom_range(1, 4);
        if (n > target - made) begin
          n = target - made;
        end
        for (int i = 0; i < n; i++) begin
          push_req(1'($urandom_range(1)), TimeWidth'($urandom), TimeWidth'($urandom));
        end
        made += n;
      end
    end
  endtask

  // Sender pause: wait out every request and level, plus the trigger tail.
  // Sampled on the falling edge so the driver's updates have settled.
  task automatic drain();
    while (pending_reqs.size() != 0 || in_valid_i || expected_levels.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: dead ticks, extreme times, slow step, retrigger during attack
    push_req(CmdTick, 16'hFFFF, 16'hFFFF);
    push_req(CmdTick, 16'h0000, 16'h0000);
    push_req(CmdTrigger, 16'h0000, 16'h0000);
    push_ticks(2);
    push_req(CmdTrigger, 16'hFFFF, 16'hFFFF);
    push_req(CmdTick, 16'hAAAA, 16'h5555);
    push_req(CmdTick, 16'h5555, 16'hAAAA);
    push_req(CmdTick, 16'hFFFF, 16'h0000);
    push_req(CmdTrigger, 16'h0001, 16'h8000);
    push_ticks(2);
    push_req(CmdTrigger, 16'hFFFF, 16'h0000);
    push_ticks(2);
    push_req(CmdTrigger, 16'h0000, 16'hFFFF);
    push_ticks(1);
    push_req(CmdTrigger, 16'h8000, 16'h0001);
    push_ticks(1);
    drain();

    // One full envelope through attack, decay and dead, then random traffic;
    // the output holds off mid-way so the block backs up
    push_req(CmdTrigger, 16'hFFFF, 16'hFFFF);
    push_ticks(620);
    push_random(100);
    repeat (60) @(posedge clk_i);
    hold_token++;
    drain();

    push_random(330);
    drain();
    repeat (16) @(posedge clk_i);

    if (pending_reqs.size() != 0 || expected_levels.size() != 0) begin
      report_mismatch($sformatf("%0d requests and %0d levels still outstanding",
                                pending_reqs.size(), expected_levels.size()));
    end

    $display("covered %0d requests (%0d triggers), %0d levels checked", req_count,
             trigger_count, levels_checked);
    $display("envelope wraps seen: %0d attack to decay, %0d decay to dead", attack_wraps,
             decay_wraps);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", error_count);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### attack_decay_envelope.f
design/ad_env_pkg.sv
design/attack_decay_envelope.sv
design/ad_env_checker.sv
sim/testbench.sv
